>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OVL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define OVL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ovl_pkg.sv
// Types and constants for the ordered value list.
`timescale 1ns / 1ps

package ovl_pkg;

    localparam int DEF_CAPACITY = 16;

    typedef enum logic [2:0] {
        CMD_PUSH_HEAD = 3'd0,
        CMD_PUSH_TAIL = 3'd1,
        CMD_POP_HEAD  = 3'd2,
        CMD_POP_TAIL  = 3'd3,
        CMD_LOOKUP    = 3'd4,
        CMD_INSERT    = 3'd5,
        CMD_DELETE    = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    // What the cell row does in the current cycle
    typedef enum logic [1:0] {
        PH_HOLD,
        PH_CMP,
        PH_SCAN,
        PH_EXEC
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SCAN,
        S_EXEC
    } t_state;

    typedef struct packed {
        t_phase phase;
        t_cmd   op;
        logic   apply;
        logic   head_hit;
        logic   tail_hit;
    } t_cell_ctl;

endpackage

>>> src/ordered_value_list.sv
// Top level of the ordered value list: command control and the row of cells.
//
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+---------------------------
//  command | in        | i_valid / o_ready  | i_cmd, i_value, i_key
//  result  | out       | o_valid / i_ready  | o_status, o_found, o_count
//
// Push, pop and any command on an empty list go from accept straight to the
// execute state, which registers the result; lookup, insert after and delete
// first pass the compare and scan states, and the match prefix ripples through
// the cell row one cell per cycle before the update. One command is in work at
// a time; the next is taken in idle when the output stage is free or is being
// read out. Reset empties the list; stored values need no clearing.
`timescale 1ns / 1ps

module ordered_value_list #(
    parameter int CAPACITY = ovl_pkg::DEF_CAPACITY
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_cmd,
    input  logic signed [31:0]   i_value,
    input  logic signed [31:0]   i_key,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic                 o_found,
    output logic [4:0]           o_count
);

    import ovl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
    localparam logic [CW-1:0] SCAN_LAST = CW'(CAPACITY - 1);

    t_state             r_state;
    t_state             n_state;
    logic [CW-1:0]      r_scan_cnt;
    logic [CW-1:0]      n_scan_cnt;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    t_cmd               r_cmd;
    logic signed [31:0] r_value;
    logic signed [31:0] r_key;
    logic               r_out_valid;
    logic               n_out_valid;
    t_status            r_out_status;
    t_status            n_status;
    logic               r_out_found;
    logic               n_found;
    logic [4:0]         r_out_count;
    logic               w_accept;
    logic               w_exec;
    logic               w_full;
    logic               w_empty;
    logic               w_any;
    logic               w_scan_cmd;
    t_cell_ctl          w_ctl;

    logic signed [31:0] w_data      [CAPACITY];
    logic signed [31:0] w_prev_data [CAPACITY];
    logic signed [31:0] w_next_data [CAPACITY];
    logic               w_prev_chain  [CAPACITY];
    logic               w_prev_before [CAPACITY];
    logic               w_chain     [CAPACITY];
    logic               w_before    [CAPACITY];
    logic               w_match     [CAPACITY];
    logic [CAPACITY-1:0] w_tail_match;

    assign o_ready  = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign w_accept = i_valid && o_ready;
    assign w_full   = r_count == CAP_C;
    assign w_empty  = r_count == '0;
    assign w_any    = w_chain[CAPACITY-1];
    assign w_scan_cmd = (t_cmd'(i_cmd) == CMD_LOOKUP) || (t_cmd'(i_cmd) == CMD_INSERT) ||
                        (t_cmd'(i_cmd) == CMD_DELETE);

    // Sequencer: next state, cell control and command result
    always_comb begin
        n_state        = r_state;
        n_scan_cnt     = r_scan_cnt;
        n_count        = r_count;
        n_status       = ST_DONE;
        n_found        = 1'b0;
        w_exec         = 1'b0;
        w_ctl.phase    = PH_HOLD;
        w_ctl.op       = r_cmd;
        w_ctl.apply    = 1'b0;
        w_ctl.head_hit = w_match[0];
        w_ctl.tail_hit = |w_tail_match;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_scan_cmd && !w_empty) ? S_CMP : S_EXEC;
                end
            end
            S_CMP: begin
                w_ctl.phase = PH_CMP;
                n_scan_cnt  = '0;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                w_ctl.phase = PH_SCAN;
                n_scan_cnt  = r_scan_cnt + 1'b1;
                if (r_scan_cnt == SCAN_LAST) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                w_ctl.phase = PH_EXEC;
                w_exec      = 1'b1;
                n_state     = S_IDLE;
                unique case (r_cmd)
                    CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_ctl.apply = 1'b1;
                            n_count     = r_count + 1'b1;
                        end
                    end
                    CMD_POP_HEAD, CMD_POP_TAIL: begin
                        if (w_empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            w_ctl.apply = 1'b1;
                            n_count     = r_count - 1'b1;
                        end
                    end
                    CMD_LOOKUP: begin
                        if (w_empty) begin
                            n_status = ST_EMPTY;
                        end else if (w_any) begin
                            n_found = 1'b1;
                        end else begin
                            n_status = ST_MISS;
                        end
                    end
                    CMD_INSERT: begin
                        if (w_empty) begin
                            n_status = ST_EMPTY;
                        end else if (!w_any) begin
                            n_status = ST_MISS;
                        end else begin
                            n_found = 1'b1;
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.apply = 1'b1;
                                n_count     = r_count + 1'b1;
                            end
                        end
                    end
                    CMD_DELETE: begin
                        if (w_empty) begin
                            n_status = ST_EMPTY;
                        end else if (!w_any) begin
                            n_status = ST_MISS;
                        end else begin
                            n_found     = 1'b1;
                            w_ctl.apply = 1'b1;
                            n_count     = r_count - 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = (r_out_valid && !i_ready) || w_exec;
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan_cnt  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan_cnt  <= n_scan_cnt;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the command beat and the result beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_value <= i_value;
            r_key   <= i_key;
        end
        if (w_exec) begin
            r_out_status <= n_status;
            r_out_found  <= n_found;
            r_out_count  <= 5'(n_count);
        end
    end

    // Row of cells, each linked to its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev_data[g]   = r_value;
            assign w_prev_chain[g]  = 1'b0;
            assign w_prev_before[g] = 1'b0;
        end else begin : g_mid
            assign w_prev_data[g]   = w_data[g-1];
            assign w_prev_chain[g]  = w_chain[g-1];
            assign w_prev_before[g] = w_before[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next_data[g] = w_data[g];
        end else begin : g_inner
            assign w_next_data[g] = w_data[g+1];
        end

        ovl_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_count       (r_count),
            .i_key         (r_key),
            .i_value       (r_value),
            .i_prev_data   (w_prev_data[g]),
            .i_next_data   (w_next_data[g]),
            .i_prev_chain  (w_prev_chain[g]),
            .i_prev_before (w_prev_before[g]),
            .o_data        (w_data[g]),
            .o_chain       (w_chain[g]),
            .o_before      (w_before[g]),
            .o_match       (w_match[g]),
            .o_tail_match  (w_tail_match[g])
        );
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_found  = r_out_found;
    assign o_count  = r_out_count;

endmodule

>>> src/ovl_cell.sv
// One list slot: stored value, key match flag and the match prefix chain.
`timescale 1ns / 1ps

module ovl_cell #(
    parameter int CAPACITY = ovl_pkg::DEF_CAPACITY,
    parameter int IDX      = 0,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ovl_pkg::t_cell_ctl   i_ctl,
    input  logic [CW-1:0]        i_count,
    input  logic signed [31:0]   i_key,
    input  logic signed [31:0]   i_value,
    input  logic signed [31:0]   i_prev_data,
    input  logic signed [31:0]   i_next_data,
    input  logic                 i_prev_chain,
    input  logic                 i_prev_before,
    output logic signed [31:0]   o_data,
    output logic                 o_chain,
    output logic                 o_before,
    output logic                 o_match,
    output logic                 o_tail_match
);

    import ovl_pkg::*;

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_N  = CW'(IDX + 1);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic               r_match;
    logic               r_before;
    logic               w_valid;
    logic               w_del_here;

    assign w_valid = IDX_C < i_count;

    // Match flag and "some earlier cell matched" flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match  <= 1'b0;
            r_before <= 1'b0;
        end else begin
            unique case (i_ctl.phase)
                PH_CMP: begin
                    r_match  <= w_valid && (r_data == i_key);
                    r_before <= 1'b0;
                end
                PH_SCAN: begin
                    r_before <= i_prev_chain;
                end
                PH_HOLD, PH_EXEC: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Delete removes this slot or one before it: head, tail, or first match
    always_comb begin
        if (i_ctl.head_hit) begin
            w_del_here = 1'b1;
        end else if (i_ctl.tail_hit) begin
            w_del_here = IDX_N >= i_count;
        end else begin
            w_del_here = r_before | r_match;
        end
    end

    // Next stored value for a list update
    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            CMD_PUSH_HEAD: n_data = (IDX == 0) ? i_value : i_prev_data;
            CMD_PUSH_TAIL: n_data = (IDX_C == i_count) ? i_value : r_data;
            CMD_POP_HEAD:  n_data = i_next_data;
            CMD_INSERT: begin
                if (i_prev_before) begin
                    n_data = i_prev_data;
                end else if (r_before) begin
                    n_data = i_value;
                end
            end
            CMD_DELETE:    n_data = w_del_here ? i_next_data : r_data;
            default:       n_data = r_data;
        endcase
    end

    // Update the slot only when the command changes the list
    always_ff @(posedge i_clk) begin
        if (i_ctl.phase == PH_EXEC && i_ctl.apply) begin
            r_data <= n_data;
        end
    end

    assign o_data       = r_data;
    assign o_chain      = r_before | r_match;
    assign o_before     = r_before;
    assign o_match      = r_match;
    assign o_tail_match = r_match && (IDX_N == i_count);

endmodule

>>> src/ovl_checker.sv
// Port-level checks for the ordered value list, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ovl_checker #(
    parameter int CAPACITY = ovl_pkg::DEF_CAPACITY
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_status,
    input logic       o_found,
    input logic [4:0] o_count
);

    import ovl_pkg::*;

    localparam logic [4:0] CAP_LOW = 5'(CAPACITY);

    // A stalled result beat keeps its payload
    `OVL_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status) && $stable(o_found) && $stable(o_count), "result beat changed while stalled")

    // A rejection for lack of room reports a full list
    `OVL_ASSERT_IMPL(a_full_count, i_clk, i_rst_n, o_valid && o_status == ST_FULL, o_count == CAP_LOW, "full status with count below capacity")

    // An empty report means no entries and no match
    `OVL_ASSERT_IMPL(a_empty, i_clk, i_rst_n, o_valid && o_status == ST_EMPTY, o_count == 5'd0 && !o_found, "empty status with entries or a match")

    // A miss never comes with a match
    `OVL_ASSERT_IMPL(a_miss, i_clk, i_rst_n, o_valid && o_status == ST_MISS, !o_found, "miss status with found set")

endmodule

bind ordered_value_list ovl_checker #(
    .CAPACITY (CAPACITY)
) u_ovl_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_status (o_status),
    .o_found  (o_found),
    .o_count  (o_count)
);
